// File: rtl/core/vbpt_pkg.sv
// Package: shared constants and types for the volume binned pressure trim block.
package vbpt_pkg;

    localparam int NUM_BINS  = 64;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int BCNT_W    = $clog2(NUM_BINS + 1);
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 32;
    localparam int TALLY_W   = 38;
    localparam int MEM_W     = SUM_W + CNT_W;
    localparam int VOL_W     = 32;
    localparam int PRES_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_BCW   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 96;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 2'd3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // divider request/response between sequencer and shared divider
    typedef struct packed {
        logic              start;
        logic [VOL_W-1:0]  dividend;
        logic [VOL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [VOL_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// File: rtl/core/vbpt_ram.sv
// Generic single-port-write, registered-read RAM.
module vbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/vbpt_div.sv
// Restoring divider, one quotient bit per cycle.
module vbpt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vbpt_pkg::div_req_t req,
    output vbpt_pkg::div_rsp_t rsp
);
    localparam int W = vbpt_pkg::VOL_W;

    logic [W-1:0]         quo_reg, quo_next;
    logic [W:0]           rem_reg, rem_next;
    logic [W-1:0]         dvs_reg, dvs_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[W-1:0], quo_reg[W-1]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(W)+1)'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// File: rtl/core/volume_binned_pressure_trim_unit.sv
// Top level: volume binned pressure accumulator with undersampled bin trim.
// Usage:
//  - s_ channel: one transfer per item. s_tuser is the kind (0 sample,
//    1 finish); s_tdata holds volume (low 32) then pressure (high 32).
//  - A sample finds its bin with the shared 32-step serial divider, then
//    reads, updates and writes the bin store. s_tready stays low until the
//    write is done. A bin past the ones in use frees the input once the
//    divider is done. Zero width or a volume below the low edge is dropped
//    at the transfer itself. No sample gives a result.
//  - A finish walks the bins in use, in states FRD, FMUL and FOUT per bin:
//    read the bin, form count*bins*256 with one multiplier, compare against
//    the registered total*fraction, send one m_ transfer, then clear that
//    bin. The first result passes FNEED, FRD, FMUL, FOUT and the output
//    register. The last result carries m_tlast and the trimmed count. A
//    clearing pass over the whole store follows before s_tready rises again.
//  - m_ channel waits in an output register: a stall holds the walk there.
//  - Reset (aresetn, sync, active low) restores the state and config registers
//    and runs a clearing pass over the 64-entry store before s_tready rises.
//  - cfg_we/cfg_addr/cfg_wdata write registers while the block is idle; this is the user's duty, unchecked.
module volume_binned_pressure_trim_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [vbpt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [vbpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [vbpt_pkg::S_TDATA_W-1:0]      s_tdata,  // volume[31:0], pressure[63:32]
    input  logic                                s_tuser,  // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bin_index[5:0], compact_index[11:6], pressure_sum[59:12],
    // hit_count[91:60], zero fill[95:92]
    output logic [vbpt_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [7:0]                          m_tuser,  // kept[0], trimmed_count[7:1]
    output logic                                m_tlast
);
    localparam int BW  = vbpt_pkg::BIN_W;
    localparam int SW  = vbpt_pkg::SUM_W;
    localparam int CW  = vbpt_pkg::CNT_W;
    localparam int TW  = vbpt_pkg::TALLY_W;
    localparam int NB  = vbpt_pkg::NUM_BINS;
    localparam int BCW = vbpt_pkg::BCNT_W;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_DIV    = 9'b000000100,
        ST_RD     = 9'b000001000,
        ST_UPD    = 9'b000010000,
        ST_FRD    = 9'b000100000,
        ST_FMUL   = 9'b001000000,
        ST_FOUT   = 9'b010000000,
        ST_FNEED  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] vmin_reg, width_reg;
    logic [6:0]  bcnt_reg;
    logic [15:0] frac_reg;

    logic [BW-1:0]  addr_reg, addr_next;
    logic [BW:0]    nbins;
    logic [31:0]    pres_reg;
    logic [TW-1:0]  tally_reg, tally_next;
    logic [TW+15:0] need_reg;
    logic [CW+BCW+8-1:0] prod_reg;
    logic [BW:0]    kept_reg, kept_next, trim_reg, trim_next;

    vbpt_pkg::div_req_t dreq;
    vbpt_pkg::div_rsp_t drsp;

    logic              ram_we;
    logic [BW-1:0]     ram_waddr, ram_raddr;
    logic [vbpt_pkg::MEM_W-1:0] ram_wdata, ram_rdata;

    logic [SW-1:0] rd_sum;
    logic [CW-1:0] rd_cnt;
    logic [SW:0]   sum_ext;
    logic [SW-1:0] sum_sat;
    logic          keep;

    logic [vbpt_pkg::M_TDATA_W-1:0] mdata_reg;
    logic [7:0] muser_reg;
    logic       mvalid_reg, mlast_reg;

    assign nbins = (bcnt_reg == 7'd0) ? (BW+1)'(1) :
                   (bcnt_reg > 7'(NB)) ? (BW+1)'(NB) : bcnt_reg[BW:0];

    vbpt_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    vbpt_ram #(.WIDTH(vbpt_pkg::MEM_W), .DEPTH(NB)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata));

    assign rd_sum = ram_rdata[SW-1:0];
    assign rd_cnt = ram_rdata[vbpt_pkg::MEM_W-1:SW];
    assign sum_ext = {rd_sum[SW-1], rd_sum} + {{(SW-31){pres_reg[31]}}, pres_reg};
    always_comb begin
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            sum_sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SW-1:0];
        end
    end
    assign keep = (rd_cnt != '0) && ({{16{1'b0}}, prod_reg} >= {{(CW+BCW+8-TW){1'b0}}, need_reg});

    assign s_tready = (state_reg == ST_IDLE);
    assign ram_raddr = addr_reg;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        tally_next = tally_reg;
        kept_next  = kept_reg;
        trim_next  = trim_reg;
        dreq       = '0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == BW'(NB - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == vbpt_pkg::KIND_FINISH) begin
                        addr_next  = '0;
                        kept_next  = '0;
                        trim_next  = '0;
                        state_next = ST_FNEED;
                    end else if (width_reg != '0 && s_tdata[31:0] >= vmin_reg) begin
                        dreq.start    = 1'b1;
                        dreq.dividend = s_tdata[31:0] - vmin_reg;
                        dreq.divisor  = width_reg;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (drsp.done) begin
                    if (drsp.quotient < 32'(nbins)) begin
                        addr_next  = drsp.quotient[BW-1:0];
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: state_next = ST_UPD;
            ST_UPD: begin
                ram_we = 1'b1;
                ram_wdata = {(rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1, sum_sat};
                if (rd_cnt != '1) begin
                    tally_next = tally_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_FNEED: state_next = ST_FRD;
            ST_FRD:   state_next = ST_FMUL;
            ST_FMUL:  state_next = ST_FOUT;
            ST_FOUT: begin
                if (!mvalid_reg || m_tready) begin
                    ram_we = 1'b1;
                    if (keep) kept_next = kept_reg + 1'b1;
                    else      trim_next = trim_reg + 1'b1;
                    if ({1'b0, addr_reg} == nbins - 1'b1) begin
                        // also clear bins beyond the ones in use
                        addr_next  = '0;
                        tally_next = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = ST_FRD;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            tally_reg  <= '0;
            vmin_reg   <= '0;
            width_reg  <= 32'd65536;
            bcnt_reg   <= 7'd64;
            frac_reg   <= 16'd26;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tally_reg <= tally_next;
            if (cfg_we) begin
                case (cfg_addr)
                    vbpt_pkg::REG_VOLUME_MIN: vmin_reg  <= cfg_wdata;
                    vbpt_pkg::REG_BIN_WIDTH:  width_reg <= cfg_wdata;
                    vbpt_pkg::REG_BIN_COUNT:  bcnt_reg  <= cfg_wdata[6:0];
                    vbpt_pkg::REG_CUTOFF:     frac_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_FOUT && (!mvalid_reg || m_tready)) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
        kept_reg <= kept_next;
        trim_reg <= trim_next;
        if (state_reg == ST_IDLE) begin
            pres_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_FNEED) begin
            need_reg <= tally_reg * frac_reg;
        end
        if (state_reg == ST_FMUL) begin
            prod_reg <= {(CW+BCW)'(rd_cnt) * (CW+BCW)'(nbins), 8'd0};
        end
        if (state_reg == ST_FOUT && (!mvalid_reg || m_tready)) begin
            mdata_reg <= {4'd0, rd_cnt, rd_sum,
                          keep ? kept_reg[BW-1:0] : BW'(0), addr_reg};
            mlast_reg <= ({1'b0, addr_reg} == nbins - 1'b1);
            muser_reg <= {({1'b0, addr_reg} == nbins - 1'b1) ?
                              7'(trim_reg + (keep ? 1'b0 : 1'b1)) : 7'd0,
                          keep};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;
endmodule

// File: rtl/core/vbpt_checker.sv
// Port-level checker for the trim unit, bound to the top level.
module vbpt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic       m_tlast,
    input logic [7:0] m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");
    a_trim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[7:1] == 7'd0) else $error("trim early");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready) else $error("reset state");
endmodule

bind volume_binned_pressure_trim_unit vbpt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tuser(m_tuser));
